// ----- hdl/ckht_pkg.sv -----
// Shared types, constants and codes for the chroma key trimap block.
`timescale 1ns / 1ps
`default_nettype none

package ckht_pkg;

  // Field and register widths
  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned KEY_W   = 8;
  localparam int unsigned TOL_W   = 17;
  localparam int unsigned CLASS_W = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 17;

  // Divider geometry: 8 quotient bits, one per stage
  localparam int unsigned NUM_W = 17;
  localparam int unsigned DEN_W = 9;
  localparam int unsigned QUO_W = 8;

  // Hue path widths
  localparam int unsigned HUE_X_W = 11;
  localparam int unsigned DIST_W  = 7;

  // Width of the fixed-point threshold compares
  localparam int unsigned CMP_W = 26;
  localparam int unsigned FRAC_BITS = 16;

  // Pipeline: two front stages, the divider stages, hue finish, classify
  localparam int unsigned NUM_STAGES = 2 + QUO_W + 2;
  localparam int unsigned DIV_FIRST  = 2;

  // Arithmetic constants
  localparam int unsigned ONE_Q16   = 65536;
  localparam int unsigned HUE_SPAN  = 180;
  localparam int unsigned HUE_HALF  = 90;
  localparam int unsigned HUE_MAX   = 179;
  localparam int unsigned SAT_SCALE = 255;
  localparam int unsigned V_MINIMUM = 13;
  localparam int unsigned RED_SHIFT = 30;
  localparam int unsigned RED_WRAP  = 150;

  // Register reset values
  localparam int unsigned KEY_HUE_RST = 60;
  localparam int unsigned BG_TOL_RST  = 6554;
  localparam int unsigned FG_TOL_RST  = 16384;
  localparam int unsigned SAT_MIN_RST = 19661;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KEY_HUE = 2'd0,
    CFG_BG_TOL  = 2'd1,
    CFG_FG_TOL  = 2'd2,
    CFG_SAT_MIN = 2'd3
  } cfg_index_e;

  // Output class codes
  typedef enum logic [CLASS_W-1:0] {
    CLASS_BACKGROUND = 2'd0,
    CLASS_UNKNOWN    = 2'd1,
    CLASS_FOREGROUND = 2'd2
  } pixel_class_e;

  // Key hue and scaled thresholds for the hue finish and classify stages
  typedef struct packed {
    logic [KEY_W-1:0] key_hue;
    logic [CMP_W-1:0] bg_limit;
    logic [CMP_W-1:0] bg_wide_limit;
    logic [CMP_W-1:0] fg_limit;
    logic [CMP_W-1:0] sat_limit;
  } cfg_t;

  // Flags that ride alongside the divider stages
  typedef struct packed {
    logic diff_zero;
    logic red_max;
    logic v_ok;
  } side_t;

endpackage

`default_nettype wire

// ----- hdl/chroma_key_hsv_trimap.sv -----
// Top level of the HSV chroma key trimap classifier.
`timescale 1ns / 1ps
`default_nettype none

// Classifies one BGR pixel per transaction as background, unknown or
// foreground against a configured key hue. The pixel is turned into 8-bit
// HSV (V the channel maximum, S = 255*(V-min)/V, H in 0..179, both rounded
// to nearest), the circular hue distance to the key is taken, and the
// distance and saturation are compared against the tolerance registers.
// Throughput is one pixel per clock while the output is not stalled.
// There are 12 register stages. The depth is set by the two 8-stage
// dividers (saturation and hue) that run side by side, plus two front
// stages (max/min, numerators) and two back stages (hue finish, threshold
// compare). Every stage has its own valid bit and moves on whenever the
// stage after it is empty or moving, so bubbles close up under output
// stall and the input is held off only when all twelve stages are full.
// There is no state between pixels. The user must write the registers
// through the plain write port only while no pixel is in flight; the
// block does not enforce this. A write takes effect for pixels accepted
// from the next cycle on.
module chroma_key_hsv_trimap import ckht_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // Configuration write port
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // Pixel input channel
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [CHAN_W-1:0]     blue_i,
  input  wire logic [CHAN_W-1:0]     green_i,
  input  wire logic [CHAN_W-1:0]     red_i,
  // Class output channel
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic [CLASS_W-1:0]         pixel_class_o
);

  typedef enum logic [1:0] {
    SEL_RED   = 2'd0,
    SEL_GREEN = 2'd1,
    SEL_BLUE  = 2'd2
  } max_sel_e;

  cfg_t cfg;

  // Per-stage valid bits and the ready chain running back from the output
  logic [NUM_STAGES-1:0] vld_q;
  logic [NUM_STAGES:0]   rdy;

  assign rdy[NUM_STAGES] = !out_stall_i;
  for (genvar k = 0; k < NUM_STAGES; k++) begin : g_rdy
    assign rdy[k] = !vld_q[k] || rdy[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (rdy[0]) begin
        vld_q[0] <= in_valid_i;
      end
      for (int k = 1; k < NUM_STAGES; k++) begin
        if (rdy[k]) begin
          vld_q[k] <= vld_q[k-1];
        end
      end
    end
  end

  assign in_stall_o = !rdy[0];

  ckht_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // ---------------------------------------------------------------------
  // Stage 0: channel maximum, minimum and spread; pick the hue sector.
  // Red wins ties over green, green over blue.
  // ---------------------------------------------------------------------
  logic [CHAN_W-1:0] v_d, mn_d;
  max_sel_e          sel_d;
  logic [CHAN_W-1:0] v0_q, diff0_q, b0_q, g0_q, r0_q;
  max_sel_e          sel0_q;

  always_comb begin
    if (red_i >= green_i && red_i >= blue_i) begin
      sel_d = SEL_RED;
      v_d   = red_i;
    end else if (green_i >= blue_i) begin
      sel_d = SEL_GREEN;
      v_d   = green_i;
    end else begin
      sel_d = SEL_BLUE;
      v_d   = blue_i;
    end
    mn_d = red_i;
    if (green_i < mn_d) mn_d = green_i;
    if (blue_i < mn_d)  mn_d = blue_i;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      v0_q    <= v_d;
      diff0_q <= v_d - mn_d;
      sel0_q  <= sel_d;
      b0_q    <= blue_i;
      g0_q    <= green_i;
      r0_q    <= red_i;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: divider operands. Round-half-up n/d is floor((2n+d)/(2d)).
  //   S: n = 255*diff, d = V.
  //   H: n = 30*x, d = diff, with x offset so it never goes negative.
  // A zero divisor is replaced by one; those cases are fixed up later.
  // ---------------------------------------------------------------------
  logic [HUE_X_W-1:0] hue_x;
  logic [NUM_W-1:0]   num_s_d, num_h_d, num_s_q, num_h_q;
  logic [DEN_W-1:0]   den_s_d, den_h_d, den_s_q, den_h_q;
  side_t              side_d, side1_q;

  always_comb begin
    case (sel0_q)
      SEL_RED:   hue_x = HUE_X_W'(g0_q) + HUE_X_W'(diff0_q) - HUE_X_W'(b0_q);
      SEL_GREEN: hue_x = HUE_X_W'(b0_q) + (HUE_X_W'(diff0_q) << 1) - HUE_X_W'(r0_q);
      SEL_BLUE:  hue_x = HUE_X_W'(r0_q) + (HUE_X_W'(diff0_q) << 2) - HUE_X_W'(g0_q);
      default:   hue_x = '0;
    endcase

    // 2*255*diff + V and 2*30*x + diff
    num_s_d = (NUM_W'(diff0_q) << 9) - (NUM_W'(diff0_q) << 1) + NUM_W'(v0_q);
    num_h_d = (NUM_W'(hue_x) << 6) - (NUM_W'(hue_x) << 2) + NUM_W'(diff0_q);

    den_s_d = (v0_q == '0)    ? DEN_W'(1) : {v0_q, 1'b0};
    den_h_d = (diff0_q == '0) ? DEN_W'(1) : {diff0_q, 1'b0};

    side_d.diff_zero = (diff0_q == '0);
    side_d.red_max   = (sel0_q == SEL_RED);
    side_d.v_ok      = (v0_q >= CHAN_W'(V_MINIMUM));
  end

  always_ff @(posedge clk_i) begin
    if (rdy[1]) begin
      num_s_q <= num_s_d;
      den_s_q <= den_s_d;
      num_h_q <= num_h_d;
      den_h_q <= den_h_d;
      side1_q <= side_d;
    end
  end

  // ---------------------------------------------------------------------
  // Stages 2..9: saturation and hue dividers side by side; flags follow.
  // ---------------------------------------------------------------------
  logic [QUO_W-1:0] div_en;
  logic [QUO_W-1:0] sat_quot, hue_quot;
  side_t            side_q [QUO_W];

  assign div_en = rdy[DIV_FIRST +: QUO_W];

  ckht_div u_div_sat (
    .clk_i  (clk_i),
    .en_i   (div_en),
    .num_i  (num_s_q),
    .den_i  (den_s_q),
    .quot_o (sat_quot)
  );

  ckht_div u_div_hue (
    .clk_i  (clk_i),
    .en_i   (div_en),
    .num_i  (num_h_q),
    .den_i  (den_h_q),
    .quot_o (hue_quot)
  );

  always_ff @(posedge clk_i) begin
    if (div_en[0]) begin
      side_q[0] <= side1_q;
    end
    for (int j = 1; j < QUO_W; j++) begin
      if (div_en[j]) begin
        side_q[j] <= side_q[j-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 10: finish the hue, take the folded distance to the key hue.
  // A grey pixel has hue 0; the red sector undoes its +30 offset.
  // ---------------------------------------------------------------------
  side_t             side_div;
  logic [QUO_W-1:0]  hue;
  logic [KEY_W-1:0]  dist_raw, dist_fold;
  logic [DIST_W-1:0] dist_q;
  logic [QUO_W-1:0]  sat_q;
  logic              v_ok_q;

  assign side_div = side_q[QUO_W-1];

  always_comb begin
    if (side_div.diff_zero) begin
      hue = '0;
    end else if (side_div.red_max) begin
      hue = (hue_quot >= QUO_W'(RED_SHIFT)) ? (hue_quot - QUO_W'(RED_SHIFT))
                                             : (hue_quot + QUO_W'(RED_WRAP));
    end else begin
      hue = hue_quot;
    end
    dist_raw  = (hue > cfg.key_hue) ? (hue - cfg.key_hue) : (cfg.key_hue - hue);
    dist_fold = (dist_raw > KEY_W'(HUE_HALF)) ? (KEY_W'(HUE_SPAN) - dist_raw) : dist_raw;
  end

  always_ff @(posedge clk_i) begin
    if (rdy[DIV_FIRST + QUO_W]) begin
      dist_q <= dist_fold[DIST_W-1:0];
      sat_q  <= sat_quot;
      v_ok_q <= side_div.v_ok;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 11: exact fixed-point compares against the scaled limits, then
  // the trimap decision; this register is the output.
  // ---------------------------------------------------------------------
  logic [CMP_W-1:0] dist_scaled, sat_scaled;
  logic             hue_close, far_key, beyond_wide, sat_ok;
  pixel_class_e     class_d, class_q;

  always_comb begin
    dist_scaled = CMP_W'(dist_q) << FRAC_BITS;
    sat_scaled  = CMP_W'(sat_q) << FRAC_BITS;
    hue_close   = (dist_scaled <= cfg.bg_limit);
    far_key     = (dist_scaled > cfg.fg_limit);
    beyond_wide = (dist_scaled > cfg.bg_wide_limit);
    sat_ok      = (sat_scaled >= cfg.sat_limit);

    if (hue_close && sat_ok && v_ok_q) begin
      class_d = CLASS_BACKGROUND;
    end else if (far_key || (!sat_ok && beyond_wide)) begin
      class_d = CLASS_FOREGROUND;
    end else begin
      class_d = CLASS_UNKNOWN;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[NUM_STAGES-1]) begin
      class_q <= class_d;
    end
  end

  assign out_valid_o   = vld_q[NUM_STAGES-1];
  assign pixel_class_o = class_q;

endmodule

`default_nettype wire

// ----- hdl/ckht_cfg.sv -----
// Configuration registers with clamping and pre-scaled compare limits.
`timescale 1ns / 1ps
`default_nettype none

module ckht_cfg import ckht_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                       cfg_o
);

  logic [KEY_W-1:0] key_q;
  logic [TOL_W-1:0] bg_q, fg_q, sm_q;
  logic [TOL_W-1:0] bg_clamp, fg_clamp, sm_clamp;
  logic [KEY_W-1:0] key_clamp;
  cfg_t             lim_d, lim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= KEY_W'(KEY_HUE_RST);
      bg_q  <= TOL_W'(BG_TOL_RST);
      fg_q  <= TOL_W'(FG_TOL_RST);
      sm_q  <= TOL_W'(SAT_MIN_RST);
    end else if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_KEY_HUE: key_q <= cfg_data_i[KEY_W-1:0];
        CFG_BG_TOL:  bg_q  <= cfg_data_i[TOL_W-1:0];
        CFG_FG_TOL:  fg_q  <= cfg_data_i[TOL_W-1:0];
        CFG_SAT_MIN: sm_q  <= cfg_data_i[TOL_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp tolerances to 1.0 and the key hue to the top of the hue range
  assign bg_clamp  = (bg_q > TOL_W'(ONE_Q16)) ? TOL_W'(ONE_Q16) : bg_q;
  assign fg_clamp  = (fg_q > TOL_W'(ONE_Q16)) ? TOL_W'(ONE_Q16) : fg_q;
  assign sm_clamp  = (sm_q > TOL_W'(ONE_Q16)) ? TOL_W'(ONE_Q16) : sm_q;
  assign key_clamp = (key_q > KEY_W'(HUE_MAX)) ? KEY_W'(HUE_MAX) : key_q;

  always_comb begin
    lim_d.key_hue       = key_clamp;
    lim_d.bg_limit      = CMP_W'(bg_clamp) * CMP_W'(HUE_SPAN);
    lim_d.bg_wide_limit = CMP_W'(bg_clamp) * CMP_W'(2 * HUE_SPAN);
    lim_d.fg_limit      = CMP_W'(fg_clamp) * CMP_W'(HUE_SPAN);
    lim_d.sat_limit     = CMP_W'(sm_clamp) * CMP_W'(SAT_SCALE);
  end

  // Register the scaled limits so the multiplies stay off the pixel path
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q.key_hue       <= KEY_W'(KEY_HUE_RST);
      lim_q.bg_limit      <= CMP_W'(BG_TOL_RST * HUE_SPAN);
      lim_q.bg_wide_limit <= CMP_W'(BG_TOL_RST * 2 * HUE_SPAN);
      lim_q.fg_limit      <= CMP_W'(FG_TOL_RST * HUE_SPAN);
      lim_q.sat_limit     <= CMP_W'(SAT_MIN_RST * SAT_SCALE);
    end else begin
      lim_q <= lim_d;
    end
  end

  assign cfg_o = lim_q;

endmodule

`default_nettype wire

// ----- hdl/ckht_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none

module ckht_div import ckht_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic [QUO_W-1:0] en_i,
  input  wire logic [NUM_W-1:0] num_i,
  input  wire logic [DEN_W-1:0] den_i,
  output logic      [QUO_W-1:0] quot_o
);

  logic [NUM_W-1:0] rem_q [QUO_W];
  logic [DEN_W-1:0] den_q [QUO_W];
  logic [QUO_W-1:0] quo_q [QUO_W];

  for (genvar j = 0; j < QUO_W; j++) begin : g_stage
    logic [NUM_W-1:0] rem_in, trial;
    logic [DEN_W-1:0] den_in;
    logic [QUO_W-1:0] quo_in;
    logic             take;

    if (j == 0) begin : g_head
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_body
      assign rem_in = rem_q[j-1];
      assign den_in = den_q[j-1];
      assign quo_in = quo_q[j-1];
    end

    // Quotient is known to fit, so the shifted divisor never overflows
    assign trial = NUM_W'(den_in) << (QUO_W - 1 - j);
    assign take  = (rem_in >= trial);

    always_ff @(posedge clk_i) begin
      if (en_i[j]) begin
        rem_q[j] <= take ? (rem_in - trial) : rem_in;
        den_q[j] <= den_in;
        quo_q[j] <= quo_in | (take ? (QUO_W'(1) << (QUO_W - 1 - j)) : QUO_W'(0));
      end
    end
  end

  assign quot_o = quo_q[QUO_W-1];

endmodule

`default_nettype wire

// ----- hdl/ckht_checker.sv -----
// Port-level checker for the chroma key trimap block, with its bind.
`timescale 1ns / 1ps
`default_nettype none

module ckht_checker import ckht_pkg::*; (
  input wire logic                  clk_i,
  input wire logic                  rst_ni,
  input wire logic                  in_valid_i,
  input wire logic                  in_stall_o,
  input wire logic                  out_valid_o,
  input wire logic                  out_stall_i,
  input wire logic [CLASS_W-1:0]    pixel_class_o
);

  // A stalled result holds its value until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pixel_class_o))
    else $error("stalled result changed or vanished");

  // Only the three trimap codes ever leave the block
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pixel_class_o == CLASS_BACKGROUND ||
                     pixel_class_o == CLASS_UNKNOWN ||
                     pixel_class_o == CLASS_FOREGROUND))
    else $error("illegal pixel class");

  // Input is held off only when the output is both full and stalled
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled while the pipeline could move");

  // Nothing comes out in the cycle after reset is seen
  assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result valid after reset");

endmodule

bind chroma_key_hsv_trimap ckht_checker u_ckht_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_valid_i),
  .in_stall_o    (in_stall_o),
  .out_valid_o   (out_valid_o),
  .out_stall_i   (out_stall_i),
  .pixel_class_o (pixel_class_o)
);

`default_nettype wire
